### hdl/mexp_pkg.sv
// Shared constants and controller/datapath interface types for the modular exponentiator.
package mexp_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int CFG_INDEX_WIDTH   = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPONENT_KEY  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS_VALUE = 2'd1;

    typedef struct packed {
        logic start_base;
        logic start_mul;
        logic take_base;
        logic take_mul;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic red_busy;
        logic exp_zero;
        logic mod_zero;
        logic out_full;
    } t_dp_status;

endpackage

### hdl/mexp_modred.sv
// Bit-serial restoring reducer: computes a double-width value modulo a single-width modulus.
module mexp_modred #(
    parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [2*OPERAND_WIDTH-1:0] i_value,
    input  logic [OPERAND_WIDTH-1:0]   i_modulus,
    output logic                       o_busy,
    output logic [OPERAND_WIDTH-1:0]   o_result
);

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(2 * W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [2*W-1:0]   r_val;
    logic [W-1:0]     r_rem;

    logic             n_busy;
    logic [CNT_W-1:0] n_cnt;
    logic [2*W-1:0]   n_val;
    logic [W-1:0]     n_rem;

    logic [W:0] w_trial;
    logic [W:0] w_diff;

    // One dividend bit enters the partial remainder per cycle.
    assign w_trial = {r_rem, r_val[2*W-1]};
    assign w_diff  = w_trial - {1'b0, i_modulus};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_val  = r_val;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(2 * W);
            n_val  = i_value;
            n_rem  = '0;
        end else if (r_busy) begin
            n_val = {r_val[2*W-2:0], 1'b0};
            if (w_trial >= {1'b0, i_modulus}) begin
                n_rem = w_diff[W-1:0];
            end else begin
                n_rem = w_trial[W-1:0];
            end
            n_cnt  = r_cnt - CNT_W'(1);
            n_busy = (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_val <= n_val;
        r_rem <= n_rem;
    end

    assign o_busy   = r_busy;
    assign o_result = r_rem;

endmodule

### hdl/mexp_dp.sv
// Datapath: configuration registers, accumulator, square, exponent shifter, reducers, result register.
module mexp_dp #(
    parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mexp_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [OPERAND_WIDTH-1:0]             i_cfg_data,
    input  logic [OPERAND_WIDTH-1:0]             i_base_value,
    input  logic                                 i_out_stall,
    input  mexp_pkg::t_dp_cmd                    i_cmd,
    output mexp_pkg::t_dp_status                 o_status,
    output logic                                 o_out_valid,
    output logic [OPERAND_WIDTH-1:0]             o_power_result,
    output logic                                 o_zero_modulus_error
);

    localparam int W = OPERAND_WIDTH;

    logic [W-1:0] r_exp_key;
    logic [W-1:0] r_mod;
    logic [W-1:0] r_acc;
    logic [W-1:0] r_sq;
    logic [W-1:0] r_exp;
    logic         r_out_valid;
    logic [W-1:0] r_out_result;
    logic         r_out_err;

    logic [2*W-1:0] w_prod_acc;
    logic [2*W-1:0] w_prod_sq;
    logic [2*W-1:0] w_red_b_in;
    logic [W-1:0]   w_red_a;
    logic [W-1:0]   w_red_b;
    logic           w_busy_a;
    logic           w_busy_b;
    logic           w_mod_zero;

    assign w_mod_zero = (r_mod == '0);
    assign w_prod_acc = {{W{1'b0}}, r_acc} * {{W{1'b0}}, r_sq};
    assign w_prod_sq  = {{W{1'b0}}, r_sq} * {{W{1'b0}}, r_sq};
    assign w_red_b_in = i_cmd.start_base ? {{W{1'b0}}, i_base_value} : w_prod_sq;

    // Lane A forms the accumulator product, lane B the square (or the initial base reduction).
    mexp_modred #(.OPERAND_WIDTH(W)) u_red_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.start_mul),
        .i_value   (w_prod_acc),
        .i_modulus (r_mod),
        .o_busy    (w_busy_a),
        .o_result  (w_red_a)
    );

    mexp_modred #(.OPERAND_WIDTH(W)) u_red_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.start_base | i_cmd.start_mul),
        .i_value   (w_red_b_in),
        .i_modulus (r_mod),
        .o_busy    (w_busy_b),
        .o_result  (w_red_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_key   <= '0;
            r_mod       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == mexp_pkg::REG_EXPONENT_KEY)) begin
                r_exp_key <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == mexp_pkg::REG_MODULUS_VALUE)) begin
                r_mod <= i_cfg_data;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_base) begin
            r_acc <= W'(1);
            r_exp <= r_exp_key;
        end
        if (i_cmd.take_base) begin
            r_sq <= w_red_b;
        end
        if (i_cmd.take_mul) begin
            if (r_exp[0]) begin
                r_acc <= w_red_a;
            end
            r_sq  <= w_red_b;
            r_exp <= {1'b0, r_exp[W-1:1]};
        end
        if (i_cmd.load_out) begin
            r_out_result <= w_mod_zero ? '0 : r_acc;
            r_out_err    <= w_mod_zero;
        end
    end

    assign o_status.red_busy = w_busy_a | w_busy_b;
    assign o_status.exp_zero = (r_exp == '0);
    assign o_status.mod_zero = w_mod_zero;
    assign o_status.out_full = r_out_valid;

    assign o_out_valid          = r_out_valid;
    assign o_power_result       = r_out_result;
    assign o_zero_modulus_error = r_out_err;

endmodule

### hdl/mexp_ctrl.sv
// Controller: sequences base reduction, per-bit multiply/square steps and result handoff.
module mexp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  mexp_pkg::t_dp_status i_status,
    output logic                 o_in_stall,
    output mexp_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BASE   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start_base = 1'b1;
                    n_state = i_status.mod_zero ? S_FINISH : S_BASE;
                end
            end
            S_BASE: begin
                if (!i_status.red_busy) begin
                    o_cmd.take_base = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                // The loop ends as soon as no set exponent bits remain.
                if (i_status.exp_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.start_mul = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (!i_status.red_busy) begin
                    o_cmd.take_mul = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_FINISH: begin
                if (!i_status.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

### hdl/modular_exponentiation.sv
// Each accepted base request yields one result, base^exponent mod modulus, using the exponent and
// modulus written through the configuration port. The work is right-to-left square-and-multiply:
// per exponent bit, the accumulator product and the square are reduced side by side in two
// bit-serial reducers, and the loop stops after the highest set exponent bit. A zero modulus
// yields 0 with the error flag, and a zero exponent yields 1. A finished result waits in an
// output register, so the next base is taken while it is still pending; one item is worked on
// at a time.
module modular_exponentiation #(
    parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mexp_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [OPERAND_WIDTH-1:0]             i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [OPERAND_WIDTH-1:0]             i_base_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [OPERAND_WIDTH-1:0]             o_power_result,
    output logic                                 o_zero_modulus_error
);

    mexp_pkg::t_dp_cmd    w_cmd;
    mexp_pkg::t_dp_status w_status;

    mexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    mexp_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_base_value         (i_base_value),
        .i_out_stall          (i_out_stall),
        .i_cmd                (w_cmd),
        .o_status             (w_status),
        .o_out_valid          (o_out_valid),
        .o_power_result       (o_power_result),
        .o_zero_modulus_error (o_zero_modulus_error)
    );

    // An error result always carries a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_modulus_error |-> o_power_result == '0)
        else $error("error result with nonzero value");

    // An accepted request keeps the input side busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not held off after a request was taken");

    // A result only appears at the end of a request's work.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a request in progress");

endmodule
